FILE: sv/vpp_pkg.sv
// Package for the vertex perspective projection block.
// Register indexes, field widths and matrix entry helper; no dependencies.
`default_nettype none
package vpp_pkg;

    typedef enum logic [2:0] {
        CFG_PROJ_COL_X = 3'd0,
        CFG_PROJ_COL_Y = 3'd1,
        CFG_PROJ_COL_W = 3'd2,
        CFG_CAMERA_X   = 3'd3,
        CFG_CAMERA_Y   = 3'd4,
        CFG_CAMERA_Z   = 3'd5,
        CFG_SCREEN_W   = 3'd6,
        CFG_SCREEN_H   = 3'd7
    } cfg_index_t;

    localparam int CoordW  = 24;
    localparam int ViewW   = 25;
    localparam int EntryW  = 16;
    localparam int ProdW   = ViewW + EntryW;
    localparam int SumW    = 43;
    localparam int NdcFrac = 16;
    localparam int NumW    = SumW + NdcFrac;
    localparam int QuotW   = 41;
    localparam int NdcW    = 42;
    localparam int SizeW   = 13;
    localparam int ColW    = 64;

    typedef logic signed [EntryW-1:0] entry_t;

    function automatic entry_t col_entry(input logic [ColW-1:0] col, input logic [1:0] row);
        entry_t e;
        e = entry_t'(col >> (EntryW * int'(row)));
        return e;
    endfunction

endpackage
`default_nettype wire

FILE: sv/vertex_perspective_projection.sv
// Vertex perspective projection and viewport mapping, fully pipelined.
// Depends on vpp_pkg.
//
// One vertex transfer per cycle is accepted while the result side is not
// stalled; each vertex passes the subtract, multiply and sum stages, then the
// two 41-stage restoring dividers (one quotient bit per stage). A stall on the
// result side freezes the whole pipeline, so nothing is dropped or repeated.
`default_nettype none
module vertex_perspective_projection #(
    parameter int COORD_FRAC_BITS  = 8,
    parameter int MATRIX_FRAC_BITS = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // vertex_x, vertex_y, vertex_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // screen_x, screen_y
    output logic [1:0]       m_tuser,  // w_zero, saturated
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import vpp_pkg::*;

    localparam int UndivSh = COORD_FRAC_BITS + MATRIX_FRAC_BITS - NdcFrac;
    localparam int UndivW  = SumW + 8;
    localparam int OutSh   = NdcFrac + 1 - COORD_FRAC_BITS;
    localparam int TW      = SumW + SizeW + 1;
    localparam logic [QuotW-1:0] QLim = QuotW'(1) << (QuotW - 1);

    // configuration
    logic [ColW-1:0] col_reg [3];
    logic signed [CoordW-1:0] cam_reg [3];
    logic [SizeW-1:0] scr_w_reg, scr_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                col_reg[c] <= '0;
                cam_reg[c] <= '0;
            end
            scr_w_reg <= SizeW'(1920);
            scr_h_reg <= SizeW'(1080);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PROJ_COL_X: col_reg[0] <= cfg_data;
                CFG_PROJ_COL_Y: col_reg[1] <= cfg_data;
                CFG_PROJ_COL_W: col_reg[2] <= cfg_data;
                CFG_CAMERA_X:   cam_reg[0] <= cfg_data[CoordW-1:0];
                CFG_CAMERA_Y:   cam_reg[1] <= cfg_data[CoordW-1:0];
                CFG_CAMERA_Z:   cam_reg[2] <= cfg_data[CoordW-1:0];
                CFG_SCREEN_W:   scr_w_reg  <= cfg_data[SizeW-1:0];
                CFG_SCREEN_H:   scr_h_reg  <= cfg_data[SizeW-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: view = vertex - camera
    logic vld1_reg;
    logic signed [ViewW-1:0] view_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                view_reg[a] <= ViewW'($signed(s_tdata[CoordW*a +: CoordW]))
                             - ViewW'(cam_reg[a]);
            end
        end
    end

    // stage 2: products
    logic vld2_reg;
    logic signed [ProdW-1:0] prod_reg [3][3];
    logic signed [SumW-1:0]  c3_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    prod_reg[c][r] <= ProdW'(view_reg[r]) * ProdW'(col_entry(col_reg[c], 2'(r)));
                end
                c3_reg[c] <= SumW'(col_entry(col_reg[c], 2'd3)) <<< COORD_FRAC_BITS;
            end
        end
    end

    // stage 3: sums
    logic vld3_reg;
    logic signed [SumW-1:0] sum_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= SumW'(prod_reg[c][0]) + SumW'(prod_reg[c][1])
                            + SumW'(prod_reg[c][2]) + c3_reg[c];
            end
        end
    end

    // stage 4 prep: magnitudes, undivided ndc
    logic [SumW-1:0] mag_x, mag_y, mag_w;
    logic [NumW-1:0] num_x, num_y;
    logic signed [UndivW-1:0] ext_x, ext_y, ush_x, ush_y;
    logic signed [NdcW-1:0] und_x, und_y;

    assign mag_x = sum_reg[0][SumW-1] ? SumW'(-sum_reg[0]) : SumW'(sum_reg[0]);
    assign mag_y = sum_reg[1][SumW-1] ? SumW'(-sum_reg[1]) : SumW'(sum_reg[1]);
    assign mag_w = sum_reg[2][SumW-1] ? SumW'(-sum_reg[2]) : SumW'(sum_reg[2]);
    assign num_x = NumW'(mag_x) << NdcFrac;
    assign num_y = NumW'(mag_y) << NdcFrac;
    assign ext_x = UndivW'(sum_reg[0]);
    assign ext_y = UndivW'(sum_reg[1]);

    generate
        if (UndivSh >= 0) begin : g_rsh
            assign ush_x = ext_x >>> UndivSh;
            assign ush_y = ext_y >>> UndivSh;
        end else begin : g_lsh
            assign ush_x = ext_x <<< (-UndivSh);
            assign ush_y = ext_y <<< (-UndivSh);
        end
    endgenerate

    localparam logic signed [UndivW-1:0] ULimP = UndivW'(1) <<< (QuotW - 1);
    always_comb begin
        und_x = (ush_x > ULimP) ? NdcW'(ULimP) :
                (ush_x < -ULimP) ? NdcW'(-ULimP) : NdcW'(ush_x);
        und_y = (ush_y > ULimP) ? NdcW'(ULimP) :
                (ush_y < -ULimP) ? NdcW'(-ULimP) : NdcW'(ush_y);
    end

    // divider pipeline
    logic                   d_vld [QuotW+1];
    logic [SumW-1:0]        d_den [QuotW+1];
    logic [NumW-1:0]        d_rx  [QuotW+1];
    logic [NumW-1:0]        d_ry  [QuotW+1];
    logic [QuotW-1:0]       d_qx  [QuotW+1];
    logic [QuotW-1:0]       d_qy  [QuotW+1];
    logic                   d_ox  [QuotW+1];
    logic                   d_oy  [QuotW+1];
    logic                   d_nx  [QuotW+1];
    logic                   d_ny  [QuotW+1];
    logic                   d_wz  [QuotW+1];
    logic signed [NdcW-1:0] d_ux  [QuotW+1];
    logic signed [NdcW-1:0] d_uy  [QuotW+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_den[0] <= mag_w;
            d_rx[0]  <= num_x;
            d_ry[0]  <= num_y;
            d_qx[0]  <= '0;
            d_qy[0]  <= '0;
            d_ox[0]  <= (num_x >> QuotW) >= NumW'(mag_w);
            d_oy[0]  <= (num_y >> QuotW) >= NumW'(mag_w);
            d_nx[0]  <= sum_reg[0][SumW-1] ^ sum_reg[2][SumW-1];
            d_ny[0]  <= sum_reg[1][SumW-1] ^ sum_reg[2][SumW-1];
            d_wz[0]  <= (sum_reg[2] == '0);
            d_ux[0]  <= und_x;
            d_uy[0]  <= und_y;
        end
    end

    generate
        for (genvar k = 0; k < QuotW; k++) begin : g_div
            localparam int Bit = QuotW - 1 - k;
            logic ge_x, ge_y;
            assign ge_x = (d_rx[k] >> Bit) >= NumW'(d_den[k]);
            assign ge_y = (d_ry[k] >> Bit) >= NumW'(d_den[k]);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    d_vld[k+1] <= 1'b0;
                end else if (adv) begin
                    d_vld[k+1] <= d_vld[k];
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    d_den[k+1] <= d_den[k];
                    d_rx[k+1]  <= ge_x ? d_rx[k] - (NumW'(d_den[k]) << Bit) : d_rx[k];
                    d_ry[k+1]  <= ge_y ? d_ry[k] - (NumW'(d_den[k]) << Bit) : d_ry[k];
                    d_qx[k+1]  <= d_qx[k] | (QuotW'(ge_x) << Bit);
                    d_qy[k+1]  <= d_qy[k] | (QuotW'(ge_y) << Bit);
                    d_ox[k+1]  <= d_ox[k];
                    d_oy[k+1]  <= d_oy[k];
                    d_nx[k+1]  <= d_nx[k];
                    d_ny[k+1]  <= d_ny[k];
                    d_wz[k+1]  <= d_wz[k];
                    d_ux[k+1]  <= d_ux[k];
                    d_uy[k+1]  <= d_uy[k];
                end
            end
        end
    endgenerate

    // ndc finalize
    logic [QuotW-1:0] fmag_x, fmag_y;
    logic signed [NdcW-1:0] dq_x, dq_y;
    assign fmag_x = (d_ox[QuotW] || d_qx[QuotW] > QLim) ? QLim : d_qx[QuotW];
    assign fmag_y = (d_oy[QuotW] || d_qy[QuotW] > QLim) ? QLim : d_qy[QuotW];
    assign dq_x = d_nx[QuotW] ? -NdcW'(fmag_x) : NdcW'(fmag_x);
    assign dq_y = d_ny[QuotW] ? -NdcW'(fmag_y) : NdcW'(fmag_y);

    logic vld5_reg, wz5_reg;
    logic signed [NdcW-1:0] ndc_x_reg, ndc_y_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            ndc_x_reg <= d_wz[QuotW] ? d_ux[QuotW] : dq_x;
            ndc_y_reg <= d_wz[QuotW] ? d_uy[QuotW] : dq_y;
            wz5_reg   <= d_wz[QuotW];
        end
    end

    // viewport multiply
    localparam logic signed [SumW-1:0] One = SumW'(1) <<< NdcFrac;
    logic vld6_reg, wz6_reg;
    logic signed [TW-1:0] tx_reg, ty_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_reg  <= TW'(One + SumW'(ndc_x_reg)) * TW'($signed({1'b0, scr_w_reg}));
            ty_reg  <= TW'(One - SumW'(ndc_y_reg)) * TW'($signed({1'b0, scr_h_reg}));
            wz6_reg <= wz5_reg;
        end
    end

    // scale and saturate
    localparam logic signed [TW-1:0] OMax = TW'(8388607);
    localparam logic signed [TW-1:0] OMin = -TW'(8388608);
    logic signed [TW-1:0] rx, ry;
    logic sat_x, sat_y;
    logic [CoordW-1:0] sx, sy;
    assign rx = tx_reg >>> OutSh;
    assign ry = ty_reg >>> OutSh;
    assign sat_x = (rx > OMax) || (rx < OMin);
    assign sat_y = (ry > OMax) || (ry < OMin);
    assign sx = (rx > OMax) ? CoordW'(OMax) : (rx < OMin) ? CoordW'(OMin) : CoordW'(rx);
    assign sy = (ry > OMax) ? CoordW'(OMax) : (ry < OMin) ? CoordW'(OMin) : CoordW'(ry);

    logic [47:0] out_data_reg;
    logic [1:0]  out_user_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= {sy, sx};
            out_user_reg <= {sat_x || sat_y, wz6_reg};
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            vld3_reg     <= 1'b0;
            d_vld[0]     <= 1'b0;
            vld5_reg     <= 1'b0;
            vld6_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg     <= s_tvalid;
            vld2_reg     <= vld1_reg;
            vld3_reg     <= vld2_reg;
            d_vld[0]     <= vld3_reg;
            vld5_reg     <= d_vld[QuotW];
            vld6_reg     <= vld5_reg;
            m_tvalid_reg <= vld6_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // checks
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable({vld1_reg, vld2_reg, vld3_reg, d_vld[0], vld5_reg, vld6_reg}))
        else $error("pipeline valid moved during stall");

    a_wz_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        d_vld[0] && d_wz[0] |-> d_ox[0] && d_oy[0])
        else $error("zero w not flagged as divider overflow");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
